// File: rtl/core/rcbr_pkg.sv
// Shared types, register codes and constants for the crop and tile reduction block.
package rcbr_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int COLS_W      = 11;
    localparam int ROWS_W      = 11;
    localparam int CROP_W      = 9;
    localparam int FACTOR_W    = 4;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE = 3'd4;

    localparam logic [COLS_W-1:0]   RST_FRAME_COLS  = 11'd1024;
    localparam logic [ROWS_W-1:0]   RST_FRAME_ROWS  = 11'd1024;
    localparam logic [CROP_W-1:0]   RST_CROP_WIDTH  = 9'd0;
    localparam logic [FACTOR_W-1:0] RST_FACTOR      = 4'd1;
    localparam logic                RST_REDUCE_MODE = 1'b0;

    localparam logic MODE_MEAN = 1'b0;
    localparam logic MODE_PICK = 1'b1;

    // reciprocal table: floor(2^RECIP_SHIFT / f), exact to within one for coordinates below 2^14
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = 15;
    localparam int FIDX_W      = 5;

    // queue entry widths cover the largest supported frame and factor
    localparam int ADDR_W      = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [COLS_W-1:0]   frame_cols;
        logic [ROWS_W-1:0]   frame_rows;
        logic [CROP_W-1:0]   crop_width;
        logic [FACTOR_W-1:0] factor;
        logic                reduce_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADD,
        OP_KEEP
    } op_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [ADDR_W-1:0]          tx;
        logic [FIDX_W-1:0]          factor;
        op_t                        op;
        logic                       emit;
        logic                       frame_end;
        logic                       mode;
    } entry_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [FIDX_W-1:0] f);
        logic [RECIP_W-1:0] r;
        unique case (f)
            5'd2:    r = 15'd8192;
            5'd3:    r = 15'd5461;
            5'd4:    r = 15'd4096;
            5'd5:    r = 15'd3276;
            5'd6:    r = 15'd2730;
            5'd7:    r = 15'd2340;
            5'd8:    r = 15'd2048;
            5'd9:    r = 15'd1820;
            5'd10:   r = 15'd1638;
            5'd11:   r = 15'd1489;
            5'd12:   r = 15'd1365;
            5'd13:   r = 15'd1260;
            5'd14:   r = 15'd1170;
            5'd15:   r = 15'd1092;
            5'd16:   r = 15'd1024;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/rcbr_front.sv
// Front end: raster counters, crop and tile classification, queue push.
module rcbr_front #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rcbr_pkg::cfg_t    cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    output logic              push,
    output rcbr_pkg::entry_t  push_data,
    input  logic              full
);
    import rcbr_pkg::*;

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int XW0 = (CCW > RCW) ? CCW : RCW;
    localparam int XW  = (XW0 > CROP_W + 1) ? XW0 : CROP_W + 1;
    localparam int FW  = $clog2(MAX_FACTOR + 1);
    localparam int PW  = XW + RECIP_W;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_REM,
        F_PUSH
    } fstate_t;

    fstate_t state_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   y_reg;
    logic            in_reg;
    logic [XW-1:0]   kc_reg;
    logic [XW-1:0]   kr_reg;
    logic [FW-1:0]   f_reg;
    logic            mode_reg;
    logic [XW-1:0]   qx_reg;
    logic [XW-1:0]   qy_reg;
    logic [FW:0]     rx_reg;
    logic [FW:0]     ry_reg;

    logic [XW-1:0]   cols;
    logic [XW-1:0]   rows;
    logic [FW-1:0]   f;
    logic            crop_on;
    logic [XW-1:0]   c;
    logic [XW:0]     c2;
    logic [XW-1:0]   kc;
    logic [XW-1:0]   kr;
    logic [XW-1:0]   colx;
    logic [XW-1:0]   rowy;
    logic [XW:0]     col_inc;
    logic [XW:0]     row_inc;
    logic            col_wrap;
    logic            row_wrap;
    logic [RECIP_W-1:0] rcp;
    logic [PW-1:0]   px;
    logic [PW-1:0]   py;
    logic [XW-1:0]   mqx;
    logic [XW-1:0]   mqy;
    logic [FW:0]     fx;
    logic            ox_big;
    logic            oy_big;
    logic [FW-1:0]   ox;
    logic [FW-1:0]   oy;
    logic [XW-1:0]   tx;
    logic [XW-1:0]   sx;
    logic [XW-1:0]   sy;
    logic            inx;
    logic            iny;
    logic            lastx;
    logic            lasty;
    logic [FW-1:0]   mid;
    logic [FW-1:0]   fm1;
    logic            tile_end;
    logic            first;
    logic            centre;
    op_t             op;
    logic            keep;

    always_comb begin
        cols = (cfg.frame_cols == '0) ? XW'(1) :
               (32'(cfg.frame_cols) > MAX_COLS) ? XW'(MAX_COLS) : XW'(cfg.frame_cols);
        rows = (cfg.frame_rows == '0) ? XW'(1) :
               (32'(cfg.frame_rows) > MAX_ROWS) ? XW'(MAX_ROWS) : XW'(cfg.frame_rows);
        f    = (cfg.factor == '0) ? FW'(1) :
               (32'(cfg.factor) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(cfg.factor);
        crop_on = (rows > XW'(cfg.crop_width)) && (cols > XW'(cfg.crop_width));
        c    = crop_on ? XW'(cfg.crop_width) : '0;
        c2   = {c, 1'b0};
        kc   = (c2 >= {1'b0, cols}) ? '0 : XW'({1'b0, cols} - c2);
        kr   = (c2 >= {1'b0, rows}) ? '0 : XW'({1'b0, rows} - c2);
        colx = XW'(col_reg);
        rowy = XW'(row_reg);
        col_inc  = (XW+1)'(colx) + (XW+1)'(1);
        row_inc  = (XW+1)'(rowy) + (XW+1)'(1);
        col_wrap = col_inc >= {1'b0, cols};
        row_wrap = row_inc >= {1'b0, rows};
    end

    always_comb begin
        rcp = recip(FIDX_W'(f_reg));
        px  = PW'(x_reg) * PW'(rcp);
        py  = PW'(y_reg) * PW'(rcp);
        mqx = qx_reg * XW'(f_reg);
        mqy = qy_reg * XW'(f_reg);
    end

    always_comb begin
        fx     = {1'b0, f_reg};
        ox_big = rx_reg >= fx;
        oy_big = ry_reg >= fx;
        ox     = FW'(ox_big ? rx_reg - fx : rx_reg);
        oy     = FW'(oy_big ? ry_reg - fx : ry_reg);
        tx     = qx_reg + XW'(ox_big);
        sx     = x_reg - XW'(ox);
        sy     = y_reg - XW'(oy);
        inx    = ({1'b0, sx} + (XW+1)'(f_reg)) <= {1'b0, kc_reg};
        iny    = ({1'b0, sy} + (XW+1)'(f_reg)) <= {1'b0, kr_reg};
        lastx  = ({1'b0, sx} + ((XW+1)'(f_reg) << 1)) > {1'b0, kc_reg};
        lasty  = ({1'b0, sy} + ((XW+1)'(f_reg) << 1)) > {1'b0, kr_reg};
        mid    = f_reg >> 1;
        fm1    = f_reg - FW'(1);
        tile_end = (ox == fm1) && (oy == fm1);
        first    = (ox == '0) && (oy == '0);
        centre   = (ox == mid) && (oy == mid);
        if (mode_reg == MODE_MEAN) begin
            op = first ? OP_LOAD : OP_ADD;
        end else begin
            op = centre ? OP_LOAD : OP_KEEP;
        end
        keep = in_reg && inx && iny && ((op != OP_KEEP) || tile_end);
    end

    always_comb begin
        push_data.sample    = sample_reg;
        push_data.tx        = ADDR_W'(tx);
        push_data.factor    = FIDX_W'(f_reg);
        push_data.op        = op;
        push_data.emit      = tile_end;
        push_data.frame_end = lastx && lasty;
        push_data.mode      = mode_reg;
    end

    assign s_tready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !full && keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_tvalid) begin
                        sample_reg <= s_tdata;
                        x_reg      <= colx - c;
                        y_reg      <= rowy - c;
                        in_reg     <= (colx >= c) && (rowy >= c);
                        kc_reg     <= kc;
                        kr_reg     <= kr;
                        f_reg      <= f;
                        mode_reg   <= cfg.reduce_mode;
                        if (col_wrap) begin
                            col_reg <= '0;
                            row_reg <= row_wrap ? '0 : RW'(row_inc);
                        end else begin
                            col_reg <= CW'(col_inc);
                        end
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    qx_reg    <= XW'(px >> RECIP_SHIFT);
                    qy_reg    <= XW'(py >> RECIP_SHIFT);
                    state_reg <= F_REM;
                end
                F_REM: begin
                    rx_reg    <= (FW+1)'(x_reg - mqx);
                    ry_reg    <= (FW+1)'(y_reg - mqy);
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (!full) begin
                        state_reg <= F_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/core/rcbr_fifo.sv
// Short queue of classified beats between the front and back ends.
module rcbr_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rcbr_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output rcbr_pkg::entry_t  pop_data,
    output logic              empty
);
    import rcbr_pkg::*;

    entry_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// File: rtl/core/rcbr_back.sv
// Back end: tile sum memory update, mean divider and result register.
module rcbr_back #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rcbr_pkg::entry_t  pop_data,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tlast
);
    import rcbr_pkg::*;

    localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int FFW  = 2 * FW;
    localparam int SW   = SAMPLE_W + 2 * $clog2(MAX_FACTOR);
    localparam int CNTW = $clog2(SW + 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_DIV,
        B_OUT
    } bstate_t;

    bstate_t state_reg;

    logic signed [SW-1:0] tile_mem [MAX_COLS];

    entry_t               cur_reg;
    logic signed [SW-1:0] rd_reg;
    logic [FFW-1:0]       ff_reg;
    logic [SW-1:0]        quo_reg;
    logic [FFW-1:0]       rem_reg;
    logic                 neg_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic                 m_tlast_reg;

    logic [FW-1:0]        fp;
    logic [FFW-1:0]       ffp;
    logic signed [SW-1:0] sv;
    logic signed [SW-1:0] newval;
    logic [FFW:0]         rem_sh;
    logic                 ge;
    logic [SW-1:0]        res;
    logic                 out_load;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_load = (state_reg == B_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        fp  = FW'(pop_data.factor);
        ffp = FFW'(fp) * FFW'(fp);
        sv  = SW'($signed(cur_reg.sample));
        case (cur_reg.op)
            OP_LOAD: newval = sv;
            OP_ADD:  newval = rd_reg + sv;
            default: newval = rd_reg;
        endcase
        rem_sh = {rem_reg, quo_reg[SW-1]};
        ge     = rem_sh >= {1'b0, ff_reg};
        res    = neg_reg ? (SW'(0) - quo_reg) : quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_reg <= tile_mem[pop_data.tx[AW-1:0]];
        end
        if ((state_reg == B_CALC) && (cur_reg.op != OP_KEEP)) begin
            tile_mem[cur_reg.tx[AW-1:0]] <= newval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!empty) begin
                        cur_reg   <= pop_data;
                        ff_reg    <= ffp;
                        state_reg <= B_CALC;
                    end
                end
                B_CALC: begin
                    rem_reg <= '0;
                    cnt_reg <= CNTW'(SW);
                    if (!cur_reg.emit) begin
                        state_reg <= B_IDLE;
                    end else if (cur_reg.mode == MODE_PICK) begin
                        quo_reg   <= newval;
                        neg_reg   <= 1'b0;
                        state_reg <= B_OUT;
                    end else begin
                        neg_reg   <= newval[SW-1];
                        quo_reg   <= newval[SW-1] ? (SW'(0) - newval) : newval;
                        state_reg <= (ff_reg == FFW'(1)) ? B_OUT : B_DIV;
                    end
                end
                B_DIV: begin
                    rem_reg <= FFW'(ge ? rem_sh - {1'b0, ff_reg} : rem_sh);
                    quo_reg <= {quo_reg[SW-2:0], ge};
                    cnt_reg <= cnt_reg - CNTW'(1);
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= res[31:0];
                        m_tlast_reg  <= cur_reg.frame_end;
                        state_reg    <= B_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/core/raster_crop_block_reduce_top.sv
// Top level of the raster crop and tile reduction block: config registers and stage wiring.
// Input: accept and count, reciprocal multiply, remainder, classify; then the next beat.
// Back end: each queued beat is read in the idle state and its tile sum updated in the
// calc state; a beat that ends a tile then goes to the output state, after restoring division
// over all sum bits (38 at MAX_FACTOR 8) for a mean result with factor above one.
// Reset: config to defaults, counters, queue and control cleared; tile sums are not cleared.
module raster_crop_block_reduce_top #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // [31:0] sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] value
    output logic                               m_tlast,
    input  logic                               cfg_wen,
    input  logic [rcbr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcbr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rcbr_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    entry_t push_data;
    logic   full;
    logic   pop;
    entry_t pop_data;
    logic   empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_cols  <= RST_FRAME_COLS;
            cfg_reg.frame_rows  <= RST_FRAME_ROWS;
            cfg_reg.crop_width  <= RST_CROP_WIDTH;
            cfg_reg.factor      <= RST_FACTOR;
            cfg_reg.reduce_mode <= RST_REDUCE_MODE;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_FRAME_COLS:  cfg_reg.frame_cols  <= cfg_wdata[COLS_W-1:0];
                REG_FRAME_ROWS:  cfg_reg.frame_rows  <= cfg_wdata[ROWS_W-1:0];
                REG_CROP_WIDTH:  cfg_reg.crop_width  <= cfg_wdata[CROP_W-1:0];
                REG_FACTOR:      cfg_reg.factor      <= cfg_wdata[FACTOR_W-1:0];
                REG_REDUCE_MODE: cfg_reg.reduce_mode <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    rcbr_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rcbr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rcbr_back #(
        .MAX_COLS   (MAX_COLS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
